// ===== rtl/core/qes_pkg.sv =====
// ----------------------------------------------------------------------------
// qes_pkg
// Widths and limits shared by the quantisation error statistics block.
// ----------------------------------------------------------------------------
package qes_pkg;

  // field and accumulator widths
  localparam int DIFF_W    = 16;
  localparam int MAE_W     = 16;
  localparam int MSE_W     = 32;
  localparam int COUNT_W   = 21;
  localparam int ABS_SUM_W = 36;
  localparam int SQ_SUM_W  = 52;
  localparam int SQ_W      = 2 * DIFF_W;

  // largest absolute difference that is kept
  localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

  // largest count that the count fields can hold
  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;

  // divider covers the widest dividend, one quotient bit per step
  localparam int DIV_STEPS = SQ_SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

endpackage

// ===== rtl/core/quant_error_statistics.sv =====
// A finite word occupies the block from acceptance through S_DIFF, S_SQ and S_ACC,
// a non-finite word through S_DIFF only; sample_stall stays high in between.
// A word marked last then adds S_START, two divisions in the shared restoring divider
// (skipped when the run had no finite word) and S_OUT, which loads the result.
// The result register frees the input side while a result waits downstream.
// Reset (synchronous, active high) clears the accumulators, sequencer and result_valid.
// ----------------------------------------------------------------------------
// quant_error_statistics
// Accumulates absolute and squared error between original and dequantised
// samples, tracks the maximum, and at end of run emits max, mean absolute and
// mean squared error with the finite and non-finite counts.
// ----------------------------------------------------------------------------
module quant_error_statistics #(
  parameter int MAX_ELEMENTS = 1048576,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample word channel
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [SAMPLE_WIDTH-1:0]         original_sample,
  input  logic [SAMPLE_WIDTH-1:0]         dequantized_sample,
  input  logic                            original_finite,
  input  logic                            last,
  // result word channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [qes_pkg::DIFF_W-1:0]      peak_abs_err,
  output logic [qes_pkg::MAE_W-1:0]       avg_abs_err,
  output logic [qes_pkg::MSE_W-1:0]       avg_sq_err,
  output logic [qes_pkg::COUNT_W-1:0]     finite_pairs,
  output logic [qes_pkg::COUNT_W-1:0]     non_finite_count
);

  localparam int DW  = qes_pkg::DIFF_W;
  localparam int CW  = qes_pkg::COUNT_W;
  localparam int AW  = qes_pkg::ABS_SUM_W;
  localparam int QW  = qes_pkg::SQ_SUM_W;
  localparam int SW  = qes_pkg::SQ_W;
  localparam int NS  = qes_pkg::DIV_STEPS;
  localparam int TW  = qes_pkg::STEP_W;
  localparam int EXT_W = (SAMPLE_WIDTH + 1 > DW) ? SAMPLE_WIDTH + 1 : DW + 1;
  localparam int CAP_INT = (MAX_ELEMENTS < qes_pkg::COUNT_LIMIT) ?
                           MAX_ELEMENTS : qes_pkg::COUNT_LIMIT;
  localparam logic [CW-1:0] COUNT_CAP = CW'(CAP_INT);
  localparam logic [TW-1:0] LAST_STEP = TW'(NS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]              state;
  logic [SAMPLE_WIDTH-1:0] orig;
  logic [SAMPLE_WIDTH-1:0] deq;
  logic                    finite;
  logic                    is_last;
  logic [DW-1:0]           abs_diff;
  logic [SW-1:0]           sq_diff;
  logic [DW-1:0]           running_max;
  logic [AW-1:0]           abs_error_sum;
  logic [QW-1:0]           squared_error_sum;
  logic [CW-1:0]           good_count;
  logic [CW-1:0]           skipped_count;
  logic [QW-1:0]           quo;
  logic [CW-1:0]           rem;
  logic [TW-1:0]           step;
  logic                    div_sq;
  logic [DW-1:0]           mae;
  logic [qes_pkg::MSE_W-1:0] mse;

  logic                    accept;
  logic                    out_free;
  logic [SAMPLE_WIDTH:0]   diff_wide;
  logic [SAMPLE_WIDTH:0]   abs_wide;
  logic [EXT_W-1:0]        abs_ext;
  logic [DW-1:0]           abs_clamped;
  logic [AW:0]             abs_sum_wide;
  logic [QW:0]             sq_sum_wide;
  logic [CW:0]             rem_shift;
  logic [CW:0]             rem_try;
  logic                    take;
  logic [CW-1:0]           rem_next;
  logic [QW-1:0]           quo_next;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // absolute difference, clamped to the field
  always_comb begin
    diff_wide = {orig[SAMPLE_WIDTH-1], orig} - {deq[SAMPLE_WIDTH-1], deq};
    abs_wide  = diff_wide[SAMPLE_WIDTH] ? (~diff_wide + 1'b1) : diff_wide;
    abs_ext   = EXT_W'(abs_wide);
    abs_clamped = (abs_ext > EXT_W'(qes_pkg::DIFF_MAX)) ? qes_pkg::DIFF_MAX :
                  DW'(abs_ext);
  end

  // saturating sums
  assign abs_sum_wide = {1'b0, abs_error_sum} + (AW + 1)'(abs_diff);
  assign sq_sum_wide  = {1'b0, squared_error_sum} + (QW + 1)'(sq_diff);

  // one restoring division step, shared by both means
  always_comb begin
    rem_shift = {rem, quo[QW-1]};
    rem_try   = rem_shift - {1'b0, good_count};
    take      = (rem_shift >= {1'b0, good_count});
    rem_next  = take ? CW'(rem_try) : CW'(rem_shift);
    quo_next  = {quo[QW-2:0], take};
  end

  // sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      running_max       <= '0;
      abs_error_sum     <= '0;
      squared_error_sum <= '0;
      good_count        <= '0;
      skipped_count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (finite) begin
            good_count <= (good_count >= COUNT_CAP) ? COUNT_CAP : good_count + 1'b1;
            state      <= S_SQ;
          end else begin
            skipped_count <= (skipped_count >= COUNT_CAP) ? COUNT_CAP :
                             skipped_count + 1'b1;
            state         <= is_last ? S_START : S_IDLE;
          end
        end
        S_SQ: begin
          abs_error_sum <= abs_sum_wide[AW] ? '1 : abs_sum_wide[AW-1:0];
          if (abs_diff > running_max) begin
            running_max <= abs_diff;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          squared_error_sum <= sq_sum_wide[QW] ? '1 : sq_sum_wide[QW-1:0];
          state             <= is_last ? S_START : S_IDLE;
        end
        S_START: begin
          state <= (good_count == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (step == LAST_STEP && div_sq) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            running_max       <= '0;
            abs_error_sum     <= '0;
            squared_error_sum <= '0;
            good_count        <= '0;
            skipped_count     <= '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid, set as a result word loads and cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      orig    <= original_sample;
      deq     <= dequantized_sample;
      finite  <= original_finite;
      is_last <= last;
    end
    if (state == S_DIFF) begin
      abs_diff <= abs_clamped;
    end
    if (state == S_SQ) begin
      sq_diff <= SW'(abs_diff) * SW'(abs_diff);
    end
    // divider load, first the absolute sum
    if (state == S_START) begin
      quo    <= QW'(abs_error_sum);
      rem    <= '0;
      step   <= '0;
      div_sq <= 1'b0;
      mae    <= '0;
      mse    <= '0;
    end
    if (state == S_DIV) begin
      if (step == LAST_STEP) begin
        if (div_sq) begin
          mse <= (|quo_next[QW-1:qes_pkg::MSE_W]) ? '1 :
                 quo_next[qes_pkg::MSE_W-1:0];
        end else begin
          mae    <= (|quo_next[QW-1:DW]) ? '1 : quo_next[DW-1:0];
          quo    <= squared_error_sum;
          rem    <= '0;
          step   <= '0;
          div_sq <= 1'b1;
        end
      end else begin
        quo  <= quo_next;
        rem  <= rem_next;
        step <= step + 1'b1;
      end
    end
    // result word
    if (state == S_OUT && out_free) begin
      peak_abs_err     <= running_max;
      avg_abs_err      <= mae;
      avg_sq_err       <= mse;
      finite_pairs     <= good_count;
      non_finite_count <= skipped_count;
    end
  end

endmodule
